FILE: src/mta_pkg.sv
`default_nettype none
package mta_pkg;

  typedef struct packed {
    logic        req_type;
    logic [9:0]  vertex_slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [9:0]  corner_a;
    logic [9:0]  corner_b;
    logic [9:0]  corner_c;
  } mta_in_t;

  typedef struct packed {
    logic [9:0]  out_vertex;
    logic [31:0] tangent_x;
    logic [31:0] tangent_y;
    logic [31:0] tangent_z;
    logic        degenerate;
    logic        last;
  } mta_out_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_FACE = 1'b1;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_DIFF,
    ST_DET,
    ST_NUM,
    ST_DIV,
    ST_TRD,
    ST_TWAIT,
    ST_AVG,
    ST_OUT
  } mta_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load_in;
    logic       write_vertex;
    logic       read_vtx;
    logic [1:0] corner;
    logic       diff;
    logic       det;
    logic [1:0] num_step;
    logic       num;
    logic       div_start;
    logic [1:0] div_comp;
    logic       trd;
    logic       avg_start;
    logic       write_tan;
    logic       out_load;
  } mta_cmd_t;

  typedef struct packed {
    logic req_is_face;
    logic div_done;
    logic avg_done;
    logic out_busy;
  } mta_sts_t;

endpackage
`default_nettype wire

FILE: src/mta_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mta_divider
  import mta_pkg::*;
#(
  parameter int unsigned NumW = 80,
  parameter int unsigned DenW = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_d;
endmodule
`default_nettype wire

FILE: src/mta_datapath.sv
`default_nettype none
module mta_datapath
  import mta_pkg::*;
#(
  parameter int unsigned VertexDepth = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mta_in_t  in_i,
  input  wire mta_cmd_t cmd_i,
  output mta_sts_t      sts_o,
  output mta_out_t      out_data_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i
);
  localparam int unsigned AW = (VertexDepth > 1) ? $clog2(VertexDepth) : 1;
  // Rounded-up reciprocal of the depth in 2^-20 units; exact for 10-bit indices.
  localparam logic [31:0] Recip =
    32'(((64'd1 << 20) + 64'(VertexDepth) - 64'd1) / 64'(VertexDepth));

  logic [95:0] pos_mem [VertexDepth];
  logic [63:0] uv_mem  [VertexDepth];
  logic [95:0] tan_mem [VertexDepth];
  logic [7:0]  cnt_mem [VertexDepth];

  mta_in_t req_q;
  logic [95:0] pos_rd_q;
  logic [63:0] uv_rd_q;
  logic [95:0] tan_rd_q;
  logic [7:0]  cnt_rd_q;

  logic signed [31:0] pa_q [3];
  logic signed [31:0] pb_q [3];
  logic signed [31:0] pc_q [3];
  logic signed [31:0] ua_q [2];
  logic signed [31:0] ub_q [2];
  logic signed [31:0] uc_q [2];
  logic signed [31:0] e1_q [3];
  logic signed [31:0] e2_q [3];
  logic signed [31:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [64:0] det_q;
  logic signed [64:0] num_q [3];
  logic signed [31:0] t_q [3];
  logic signed [31:0] avg_q [3];
  logic               degen_q;

  logic [AW-1:0] addr [3];

  // Index modulo the depth: the quotient comes from a constant reciprocal
  // multiply, and the remainder is what is left.
  function automatic logic [AW-1:0] mod_idx(input logic [9:0] v);
    logic [31:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 32'(v) * Recip;
    q    = prod >> 20;
    r    = 32'(v) - q * 32'(VertexDepth);
    return r[AW-1:0];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) return QMAX;
    if (v < -33'sh0_7FFF_FFFF) return -QMAX;
    return v[31:0];
  endfunction

  assign addr[0] = mod_idx(req_q.corner_a);
  assign addr[1] = mod_idx(req_q.corner_b);
  assign addr[2] = mod_idx(req_q.corner_c);

  logic [AW-1:0] rd_addr;
  assign rd_addr = addr[cmd_i.corner];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) req_q <= in_i;
    if (cmd_i.write_vertex) begin
      pos_mem[mod_idx(req_q.vertex_slot)] <= {req_q.pos_x, req_q.pos_y, req_q.pos_z};
      uv_mem[mod_idx(req_q.vertex_slot)]  <= {req_q.tex_u, req_q.tex_v};
      cnt_mem[mod_idx(req_q.vertex_slot)] <= 8'd0;
    end
    if (cmd_i.write_tan) begin
      tan_mem[rd_addr] <= {avg_q[0], avg_q[1], avg_q[2]};
      cnt_mem[rd_addr] <= cnt_rd_q + 8'd1;
    end
    pos_rd_q <= pos_mem[rd_addr];
    uv_rd_q  <= uv_mem[rd_addr];
    tan_rd_q <= tan_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  // Gather corner reads; a read issued in one cycle lands the next.
  logic [1:0] cap_q;
  logic       cap_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
      cap_q   <= '0;
    end else begin
      cap_v_q <= cmd_i.read_vtx;
      cap_q   <= cmd_i.corner;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_v_q) begin
      unique case (cap_q)
        2'd0: begin
          pa_q[0] <= pos_rd_q[95:64]; pa_q[1] <= pos_rd_q[63:32];
          pa_q[2] <= pos_rd_q[31:0];
          ua_q[0] <= uv_rd_q[63:32];  ua_q[1] <= uv_rd_q[31:0];
        end
        2'd1: begin
          pb_q[0] <= pos_rd_q[95:64]; pb_q[1] <= pos_rd_q[63:32];
          pb_q[2] <= pos_rd_q[31:0];
          ub_q[0] <= uv_rd_q[63:32];  ub_q[1] <= uv_rd_q[31:0];
        end
        default: begin
          pc_q[0] <= pos_rd_q[95:64]; pc_q[1] <= pos_rd_q[63:32];
          pc_q[2] <= pos_rd_q[31:0];
          uc_q[0] <= uv_rd_q[63:32];  uc_q[1] <= uv_rd_q[31:0];
        end
      endcase
    end
    if (cmd_i.diff) begin
      for (int j = 0; j < 3; j++) begin
        e1_q[j] <= sat33(33'(pb_q[j]) - 33'(pa_q[j]));
        e2_q[j] <= sat33(33'(pc_q[j]) - 33'(pa_q[j]));
      end
      d1u_q <= sat33(33'(ub_q[0]) - 33'(ua_q[0]));
      d1v_q <= sat33(33'(ub_q[1]) - 33'(ua_q[1]));
      d2u_q <= sat33(33'(uc_q[0]) - 33'(ua_q[0]));
      d2v_q <= sat33(33'(uc_q[1]) - 33'(ua_q[1]));
    end
    if (cmd_i.det) begin
      p1_q <= d1u_q * d2v_q;
      p2_q <= d1v_q * d2u_q;
    end
    if (cmd_i.num) begin
      // One component per step: products then difference.
      p1_q <= d2v_q * e1_q[cmd_i.num_step];
      p2_q <= d1v_q * e2_q[cmd_i.num_step];
    end
  end

  // Product pair lands in the cycle after issue; fold into det or numerator.
  logic       det_v_q, num_v_q;
  logic [1:0] num_sel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_v_q   <= 1'b0;
      num_v_q   <= 1'b0;
      num_sel_q <= '0;
    end else begin
      det_v_q   <= cmd_i.det;
      num_v_q   <= cmd_i.num;
      num_sel_q <= cmd_i.num_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (det_v_q) begin
      det_q   <= 65'(p1_q) - 65'(p2_q);
      degen_q <= (p1_q == p2_q);
    end
    if (num_v_q) num_q[num_sel_q] <= 65'(p1_q) - 65'(p2_q);
  end

  // Tangent division: |num| << 16 / |det|, 80-bit numerator.
  logic [64:0] num_mag, det_mag;
  logic [79:0] quo;
  logic        div_done;
  logic        neg_q;
  assign num_mag = num_q[cmd_i.div_comp][64] ? 65'(-num_q[cmd_i.div_comp])
                                               : 65'(num_q[cmd_i.div_comp]);
  assign det_mag = det_q[64] ? 65'(-det_q) : 65'(det_q);

  mta_divider #(.NumW(80), .DenW(64)) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({num_mag[63:0], 16'd0}),
    .den_i  (det_mag[63:0]),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic [1:0] div_sel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q     <= num_q[cmd_i.div_comp][64] ^ det_q[64];
      div_sel_q <= cmd_i.div_comp;
    end
    if (div_done) begin
      if (degen_q) t_q[div_sel_q] <= '0;
      else if (quo > 80'(QMAX)) t_q[div_sel_q] <= neg_q ? -QMAX : QMAX;
      else t_q[div_sel_q] <= neg_q ? -$signed(quo[31:0]) : $signed(quo[31:0]);
    end
  end

  // Running average: (old*c + t)/(c+1), three dividers in parallel.
  logic [2:0]         avg_done;
  logic [2:0]         aneg_q;
  logic [39:0]        aquo [3];
  logic [8:0]         cplus;
  assign cplus = 9'(cnt_rd_q) + 9'd1;

  for (genvar j = 0; j < 3; j++) begin : g_avg
    logic signed [31:0] old_t;
    logic signed [40:0] acc;
    logic [40:0]        amag;
    // A zero count means the stored tangent is stale and is replaced outright.
    assign old_t = (cnt_rd_q == 8'd0) ? 32'sd0 : $signed(tan_rd_q[95-32*j -: 32]);
    assign acc  = 41'(old_t) * $signed({33'd0, cnt_rd_q}) + 41'(t_q[j]);
    assign amag = acc[40] ? 41'(-acc) : 41'(acc);
    mta_divider #(.NumW(40), .DenW(9)) u_adiv (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(cmd_i.avg_start),
      .num_i  (amag[39:0]),
      .den_i  (cplus),
      .done_o (avg_done[j]),
      .quo_o  (aquo[j])
    );
    always_ff @(posedge clk_i) begin
      if (cmd_i.avg_start) aneg_q[j] <= acc[40];
      if (avg_done[j]) avg_q[j] <= aneg_q[j] ? -$signed(aquo[j][31:0])
                                               : $signed(aquo[j][31:0]);
    end
  end

  // Output register.
  mta_out_t out_q;
  logic     out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (cmd_i.out_load) out_v_q <= 1'b1;
    else if (out_ready_i) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_vertex <= (cmd_i.corner == 2'd0) ? req_q.corner_a :
                          (cmd_i.corner == 2'd1) ? req_q.corner_b : req_q.corner_c;
      out_q.tangent_x  <= avg_q[0];
      out_q.tangent_y  <= avg_q[1];
      out_q.tangent_z  <= avg_q[2];
      out_q.degenerate <= degen_q;
      out_q.last       <= (cmd_i.corner == 2'd2);
    end
  end

  assign out_data_o        = out_q;
  assign out_valid_o       = out_v_q;
  assign sts_o.req_is_face = (req_q.req_type == REQ_FACE);
  assign sts_o.div_done    = div_done;
  assign sts_o.avg_done    = avg_done[0];
  assign sts_o.out_busy    = out_v_q && !out_ready_i;

  logic unused;
  assign unused = cmd_i.trd ^ (|avg_done[2:1]) ^ num_mag[64] ^ det_mag[64]
                ^ (|aquo[0][39:32]) ^ (|aquo[1][39:32]) ^ (|aquo[2][39:32]);
endmodule
`default_nettype wire

FILE: src/mta_controller.sv
`default_nettype none
module mta_controller
  import mta_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire mta_sts_t sts_i,
  output mta_cmd_t      cmd_o
);
  mta_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       ld_q, ld_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ld_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ld_d    = 1'b1;
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        if (!sts_i.req_is_face) state_d = ST_IDLE;
        else state_d = ST_RD_B;
      end
      ST_RD_B: state_d = ST_RD_C;
      ST_RD_C: state_d = ST_TWAIT;
      ST_TWAIT: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_DET;
      ST_DET: begin
        state_d = ST_NUM;
        k_d     = 2'd0;
      end
      ST_NUM: begin
        if (k_q == 2'd2) begin
          state_d = ST_DIV;
          k_d     = 2'd0;
          ld_d    = 1'b1;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_DIV: begin
        if (ld_q) begin
          state_d = ST_DIV;
        end else if (sts_i.div_done) begin
          if (k_q == 2'd2) begin
            state_d = ST_TRD;
            k_d     = 2'd0;
          end else begin
            k_d  = k_q + 2'd1;
            ld_d = 1'b1;
          end
        end
      end
      ST_TRD: begin
        state_d = ST_AVG;
        ld_d    = 1'b1;
      end
      ST_AVG: begin
        if (!ld_q && sts_i.avg_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          if (k_q == 2'd2) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_TRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.load_in = (state_q == ST_IDLE) && in_valid_i;
    unique case (state_q)
      ST_RD_A: begin
        cmd_o.write_vertex = !sts_i.req_is_face;
        cmd_o.read_vtx     = sts_i.req_is_face;
        cmd_o.corner       = 2'd0;
      end
      ST_RD_B: begin cmd_o.read_vtx = 1'b1; cmd_o.corner = 2'd1; end
      ST_RD_C: begin cmd_o.read_vtx = 1'b1; cmd_o.corner = 2'd2; end
      ST_DIFF: cmd_o.diff = 1'b1;
      ST_DET:  cmd_o.det = 1'b1;
      ST_NUM: begin cmd_o.num = 1'b1; cmd_o.num_step = k_q; end
      ST_DIV: begin
        cmd_o.div_start = ld_q;
        cmd_o.div_comp  = k_q;
      end
      ST_TRD: begin cmd_o.trd = 1'b1; cmd_o.corner = k_q; end
      ST_AVG: begin
        cmd_o.corner    = k_q;
        cmd_o.avg_start = ld_q;
      end
      ST_OUT: begin
        cmd_o.corner    = k_q;
        cmd_o.write_tan = !sts_i.out_busy;
        cmd_o.out_load  = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      ld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ld_q    <= ld_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/mesh_tangent_accumulator.sv
`default_nettype none
// Per-face tangent accumulator. A load beat writes one vertex's position and
// texture coordinate and clears its contribution count; it gives no result.
// A face beat reads its three corners, forms the edges and UV deltas, and
// divides each edge combination by the UV determinant on a bit-serial
// divider, one quotient bit per cycle over 80 bits, three times in turn.
// Each corner's stored tangent is then folded into a running average by
// three parallel 40-step dividers and written back, corners in order, so a
// repeated corner sees its earlier update. After a face is accepted, the
// block reads the corners and forms the products, runs the three tangent
// divisions, then takes each corner through its tangent read, average
// division, write-back and result, and returns to idle, where the next
// beat can be accepted; a result that waits for the sink holds it back.
// A load returns to idle once its vertex is written. Three result beats
// follow each face, the last marked. Faces must name loaded vertices only.
// Items are taken one at a time.
module mesh_tangent_accumulator
  import mta_pkg::*;
#(
  parameter int unsigned VERTEX_DEPTH = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire mta_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output mta_out_t     out_data_o
);
  mta_cmd_t cmd;
  mta_sts_t sts;

  mta_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mta_datapath #(.VertexDepth(VERTEX_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );
endmodule
`default_nettype wire
